### src/batlvl_pkg.sv
package batlvl_pkg;

  localparam int CURVE_MAX = 8;
  localparam int CURVE_POINTS_DEFAULT = 4;
  localparam int SEG_W = 3;
  localparam int RECIP_SHIFT = 16;

  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [11:0] REFERENCE_RESET = 12'd3100;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ENABLE  = 2'd1,
    MODE_DISABLE = 2'd2
  } mode_t;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_REFERENCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV,
    ST_SEG,
    ST_NUM,
    ST_QUO,
    ST_CHK,
    ST_FIX,
    ST_DONE
  } state_t;

  // Curve points; points past the fourth repeat the last one.
  localparam logic signed [13:0] CURVE_MV [CURVE_MAX] = '{
    14'sd3227, 14'sd3608, 14'sd4017, 14'sd4150,
    14'sd4150, 14'sd4150, 14'sd4150, 14'sd4150
  };
  localparam logic [6:0] CURVE_PCT [CURVE_MAX] = '{
    7'd0, 7'd5, 7'd86, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  // Per segment i (from point i-1 to point i): millivolt span, percent rise
  // and floor(2^16 / span). Entry 0 is unused.
  localparam logic [9:0] CURVE_SPAN [CURVE_MAX] = '{
    10'd0, 10'd381, 10'd409, 10'd133, 10'd0, 10'd0, 10'd0, 10'd0
  };
  localparam logic [6:0] CURVE_RISE [CURVE_MAX] = '{
    7'd0, 7'd5, 7'd81, 7'd14, 7'd0, 7'd0, 7'd0, 7'd0
  };
  localparam logic [9:0] CURVE_RECIP [CURVE_MAX] = '{
    10'd0, 10'd172, 10'd160, 10'd492, 10'd0, 10'd0, 10'd0, 10'd0
  };

endpackage

### src/battery_level_estimator_top.sv
// Battery level estimator.
// Input stream (s_*): one item per tick or notification event. s_tuser holds
// the mode (tick, notify enabled, notify disabled); s_tdata the flags and the
// ADC sample. Every accepted item gives exactly one result item on m_*.
// A tick counts the period down and, at zero or on an immediate request,
// measures: millivolts from sample and reference, then a percent level from
// the piecewise-linear curve. The user must write the registers over the APB
// port only while the block is idle; the block itself does not enforce this.
// Sequencing: one shared 17x13 multiplier is stepped by a small sequencer. An
// item that does not measure goes from IDLE to DONE, a measurement clamped at
// either end of the curve passes MV and SEG, and an interpolated measurement
// also passes NUM, QUO, CHK and FIX. s_tready is high only while idle.
// The result sits in an output register; the next item is accepted while it
// waits, and a following result holds in the sequencer until m_tready frees
// the register. Reset (rst, synchronous) reloads both registers with their
// defaults, restarts the period count and clears the notify flag.
module battery_level_estimator_top #(
  parameter int CURVE_POINTS = batlvl_pkg::CURVE_POINTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] immediate, [12:1] adc_sample, [13] service_match, [14] update_failed
  input  logic [15:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [13:0] millivolts, [20:14] battery_percent, [21] send_as_notify
  output logic [23:0] m_tdata,
  // [0] measured
  output logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NPTS = (CURVE_POINTS < 2) ? 2 :
                        ((CURVE_POINTS > batlvl_pkg::CURVE_MAX) ?
                         batlvl_pkg::CURVE_MAX : CURVE_POINTS);

  batlvl_pkg::state_t state, state_next;

  logic [15:0] measure_period;
  logic [11:0] reference_mv;
  logic [15:0] period_countdown;
  logic        notify_enabled;

  logic signed [16:0] mul_a;
  logic signed [12:0] mul_b;
  logic signed [29:0] prod;

  logic signed [13:0] mv_r;
  logic [batlvl_pkg::SEG_W-1:0] seg_r;
  logic signed [13:0] diff_r;
  logic [15:0] num_r;
  logic [6:0]  quo_r;

  logic        res_measured;
  logic signed [13:0] res_mv;
  logic [6:0]  res_pct;
  logic        res_notify;

  logic        accept;
  logic        out_load;
  logic [15:0] count_dec;
  logic        do_measure;
  logic [1:0]  in_mode;
  logic        in_immediate;
  logic signed [11:0] in_sample;
  logic        in_match;
  logic        in_failed;

  logic signed [29:0] mv_bias;
  logic signed [29:0] mv_sum;
  logic signed [13:0] mv_val;

  logic [batlvl_pkg::SEG_W-1:0] seg;
  logic [batlvl_pkg::SEG_W-1:0] seg_prev;
  logic        clamp_lo;
  logic        clamp_hi;
  logic [15:0] rem;
  logic [6:0]  quo_fix;

  logic cfg_write;

  assign in_mode      = s_tuser;
  assign in_immediate = s_tdata[0];
  assign in_sample    = s_tdata[12:1];
  assign in_match     = s_tdata[13];
  assign in_failed    = s_tdata[14];

  assign count_dec  = period_countdown - 16'd1;
  assign do_measure = (count_dec == 16'd0) || in_immediate;

  // APB
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      batlvl_pkg::REG_PERIOD:    prdata = {16'd0, measure_period};
      batlvl_pkg::REG_REFERENCE: prdata = {20'd0, reference_mv};
      default:                   prdata = 32'd0;
    endcase
  end

  // Millivolts: product / 1024 truncated toward zero.
  assign mv_bias = prod[29] ? 30'sd1023 : 30'sd0;
  assign mv_sum  = prod + mv_bias;
  assign mv_val  = mv_sum[23:10];

  // Segment search: first point above the voltage.
  always_comb begin
    seg = batlvl_pkg::SEG_W'(NPTS - 1);
    for (int i = NPTS - 1; i >= 1; i--) begin
      if (mv_r < batlvl_pkg::CURVE_MV[i]) seg = batlvl_pkg::SEG_W'(i);
    end
  end
  assign clamp_lo = (mv_r <= batlvl_pkg::CURVE_MV[0]);
  assign clamp_hi = (mv_r >= batlvl_pkg::CURVE_MV[NPTS-1]);
  assign seg_prev = seg_r - batlvl_pkg::SEG_W'(1);

  // Quotient estimate is low by at most one; fix with the remainder.
  assign rem     = num_r - prod[15:0];
  assign quo_fix = quo_r + ((rem >= {6'd0, batlvl_pkg::CURVE_SPAN[seg_r]}) ? 7'd1 : 7'd0);

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      batlvl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        mul_a    = 17'(in_sample);
        mul_b    = $signed({1'b0, reference_mv});
        if (s_tvalid) begin
          if ((in_mode == batlvl_pkg::MODE_TICK) && do_measure) begin
            state_next = batlvl_pkg::ST_MV;
          end else begin
            state_next = batlvl_pkg::ST_DONE;
          end
        end
      end
      batlvl_pkg::ST_MV:  state_next = batlvl_pkg::ST_SEG;
      batlvl_pkg::ST_SEG: begin
        if (clamp_lo || clamp_hi || (batlvl_pkg::CURVE_SPAN[seg] == 10'd0)) begin
          state_next = batlvl_pkg::ST_DONE;
        end else begin
          state_next = batlvl_pkg::ST_NUM;
        end
      end
      batlvl_pkg::ST_NUM: begin
        mul_a      = 17'(diff_r);
        mul_b      = $signed({6'd0, batlvl_pkg::CURVE_RISE[seg_r]});
        state_next = batlvl_pkg::ST_QUO;
      end
      batlvl_pkg::ST_QUO: begin
        mul_a      = $signed({1'b0, prod[15:0]});
        mul_b      = $signed({3'd0, batlvl_pkg::CURVE_RECIP[seg_r]});
        state_next = batlvl_pkg::ST_CHK;
      end
      batlvl_pkg::ST_CHK: begin
        mul_a      = $signed({10'd0, prod[batlvl_pkg::RECIP_SHIFT +: 7]});
        mul_b      = $signed({3'd0, batlvl_pkg::CURVE_SPAN[seg_r]});
        state_next = batlvl_pkg::ST_FIX;
      end
      batlvl_pkg::ST_FIX: state_next = batlvl_pkg::ST_DONE;
      batlvl_pkg::ST_DONE: begin
        out_load = !m_tvalid || m_tready;
        if (out_load) state_next = batlvl_pkg::ST_IDLE;
      end
      default: state_next = batlvl_pkg::ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= batlvl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_period   <= batlvl_pkg::PERIOD_RESET;
      reference_mv     <= batlvl_pkg::REFERENCE_RESET;
      period_countdown <= batlvl_pkg::PERIOD_RESET;
      notify_enabled   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          batlvl_pkg::REG_PERIOD:    measure_period <= pwdata[15:0];
          batlvl_pkg::REG_REFERENCE: reference_mv <= pwdata[11:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (in_mode)
          batlvl_pkg::MODE_TICK: begin
            period_countdown <= do_measure ? measure_period : count_dec;
            if (do_measure && in_failed) notify_enabled <= 1'b0;
          end
          batlvl_pkg::MODE_ENABLE:  if (in_match) notify_enabled <= 1'b1;
          batlvl_pkg::MODE_DISABLE: if (in_match) notify_enabled <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      res_measured <= (in_mode == batlvl_pkg::MODE_TICK) && do_measure;
      res_notify   <= (in_mode == batlvl_pkg::MODE_TICK) && do_measure && notify_enabled;
      res_mv       <= '0;
      res_pct      <= '0;
    end
    if (state == batlvl_pkg::ST_MV) begin
      mv_r   <= mv_val;
      res_mv <= mv_val;
    end
    if (state == batlvl_pkg::ST_SEG) begin
      seg_r  <= seg;
      diff_r <= mv_r - batlvl_pkg::CURVE_MV[seg - batlvl_pkg::SEG_W'(1)];
      if (clamp_lo) begin
        res_pct <= batlvl_pkg::CURVE_PCT[0];
      end else if (clamp_hi) begin
        res_pct <= batlvl_pkg::CURVE_PCT[NPTS-1];
      end else begin
        res_pct <= batlvl_pkg::CURVE_PCT[seg];
      end
    end
    if (state == batlvl_pkg::ST_QUO) num_r <= prod[15:0];
    if (state == batlvl_pkg::ST_CHK) quo_r <= prod[batlvl_pkg::RECIP_SHIFT +: 7];
    if (state == batlvl_pkg::ST_FIX) begin
      res_pct <= batlvl_pkg::CURVE_PCT[seg_prev] + quo_fix;
    end
    if (out_load) begin
      m_tdata <= {2'd0, res_notify, res_pct, res_mv};
      m_tuser <= res_measured;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### tb/battery_level_checker.sv
`timescale 1ns / 1ps

module battery_level_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);

  localparam int N_POINTS = 4;
  localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;
  localparam logic [11:0] REFERENCE_DEFAULT = 12'd3100;
  localparam int ADC_SCALE = 2048;

  typedef struct packed {
    logic               measured;
    logic signed [13:0] millivolts;
    logic [6:0]         percent;
    logic               notify;
  } level_result_t;

  logic [15:0]   period_reg;
  logic [11:0]   reference_reg;
  logic [15:0]   countdown;
  logic          notify_on;
  level_result_t level_q[$];

  function automatic int curve_mv_at(int idx);
    case (idx)
      0: return 3227;
      1: return 3608;
      2: return 4017;
      default: return 4150;
    endcase
  endfunction

  function automatic int curve_pct_at(int idx);
    case (idx)
      0: return 0;
      1: return 5;
      2: return 86;
      default: return 100;
    endcase
  endfunction

  // Clamp at both ends, interpolate with truncation in between.
  function automatic int percent_of_mv(int mv);
    int idx;
    if (mv <= curve_mv_at(0)) return curve_pct_at(0);
    if (mv >= curve_mv_at(N_POINTS - 1)) return curve_pct_at(N_POINTS - 1);
    for (idx = 1; idx < N_POINTS; idx++) begin
      if (mv < curve_mv_at(idx)) begin
        return curve_pct_at(idx - 1) +
               ((curve_pct_at(idx) - curve_pct_at(idx - 1)) * (mv - curve_mv_at(idx - 1))) /
               (curve_mv_at(idx) - curve_mv_at(idx - 1));
      end
    end
    return curve_pct_at(N_POINTS - 1);
  endfunction

  // Advance the countdown and notify flag for one item and form its result.
  function automatic level_result_t estimate_level(logic [1:0] mode_bits, logic [15:0] data);
    level_result_t      res;
    logic signed [11:0] sample_v;
    int                 sample_i;
    int                 ref_i;
    int                 mv_i;
    int                 pct_i;
    res = '0;
    sample_v = data[12:1];
    sample_i = int'(sample_v);
    ref_i = int'(reference_reg);
    case (mode_bits)
      batlvl_pkg::MODE_TICK: begin
        countdown = countdown - 16'd1;
        if (countdown == 16'd0 || data[0]) begin
          countdown = period_reg;
          mv_i = (sample_i * ref_i * 2) / ADC_SCALE;
          pct_i = percent_of_mv(mv_i);
          res.measured = 1'b1;
          res.millivolts = mv_i[13:0];
          res.percent = pct_i[6:0];
          res.notify = notify_on;
          if (data[14]) notify_on = 1'b0;
        end
      end
      batlvl_pkg::MODE_ENABLE: if (data[13]) notify_on = 1'b1;
      batlvl_pkg::MODE_DISABLE: if (data[13]) notify_on = 1'b0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    level_result_t want;
    if (rst) begin
      period_reg = PERIOD_DEFAULT;
      reference_reg = REFERENCE_DEFAULT;
      countdown = PERIOD_DEFAULT;
      notify_on = 1'b0;
      level_q.delete();
      outstanding <= 0;
    end else begin
      // A result can never belong to an item accepted at the same edge: check first.
      if (m_tvalid && m_tready) begin
        if (level_q.size() == 0) begin
          report_mismatch("unexpected result, measured", int'(m_tuser[0]), 0);
        end else begin
          want = level_q.pop_front();
          if (m_tuser[0] !== want.measured)
            report_mismatch("measured", int'(m_tuser[0]), int'(want.measured));
          if (m_tdata[13:0] !== want.millivolts)
            report_mismatch("millivolts", int'($signed(m_tdata[13:0])),
                            int'(want.millivolts));
          if (m_tdata[20:14] !== want.percent)
            report_mismatch("battery_percent", int'(m_tdata[20:14]), int'(want.percent));
          if (m_tdata[21] !== want.notify)
            report_mismatch("send_as_notify", int'(m_tdata[21]), int'(want.notify));
        end
      end
      if (s_tvalid && s_tready)
        level_q.push_back(estimate_level(s_tuser, s_tdata));
      if (psel && penable && pwrite && pready) begin
        if (paddr == {batlvl_pkg::REG_PERIOD, 2'b00}) period_reg = pwdata[15:0];
        else if (paddr == {batlvl_pkg::REG_REFERENCE, 2'b00}) reference_reg = pwdata[11:0];
      end
      outstanding <= level_q.size();
    end
  end

endmodule

### tb/tb_battery_level_estimator_top.sv
`timescale 1ns / 1ps

module tb_battery_level_estimator_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_PERIOD = {batlvl_pkg::REG_PERIOD, 2'b00};
  localparam logic [2:0] ADDR_REFERENCE = {batlvl_pkg::REG_REFERENCE, 2'b00};
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int outstanding;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  battery_level_estimator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  battery_level_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Mostly no gap, some short ones, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(logic [1:0] mode_bits, bit imm, logic [11:0] sample, bit match,
                           bit failed);
    int gap;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode_bits;
    s_tdata <= {1'b0, failed, match, sample, imm};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every result, then give the sequencer time to settle.
  // Step one edge first so the count includes an item accepted at this edge.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_item(int ref_now);
    int          r;
    int          target;
    int          s;
    logic [1:0]  mode_bits;
    logic [11:0] sample;
    r = $urandom_range(0, 99);
    if (r < 78) mode_bits = batlvl_pkg::MODE_TICK;
    else if (r < 87) mode_bits = batlvl_pkg::MODE_ENABLE;
    else if (r < 96) mode_bits = batlvl_pkg::MODE_DISABLE;
    else mode_bits = MODE_UNUSED;
    // Half the samples aim at millivolts around the curve's range.
    if ($urandom_range(0, 1) == 0) begin
      target = $urandom_range(3150, 4250);
      s = target * 1024 / ref_now;
      if (s > 2047) s = 2047;
      sample = s[11:0];
    end else begin
      sample = 12'($urandom);
    end
    push_item(mode_bits, $urandom_range(0, 3) == 0, sample, $urandom_range(0, 3) != 0,
              $urandom_range(0, 4) == 0);
  endtask

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // Long hold-off: the block fills up and must stall its input.
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!rx_idle_on) begin
        m_tready <= 1'b1;
      end else begin
        int stall;
        stall = gap_len();
        if (stall == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int          ph;
    int          n;
    logic [15:0] period_v;
    logic [11:0] ref_v;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= batlvl_pkg::MODE_TICK;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings (period 1000, reference 3100).
    push_item(batlvl_pkg::MODE_ENABLE, 1'b1, 12'h000, 1'b0, 1'b1);   // unmatched event
    push_item(batlvl_pkg::MODE_TICK, 1'b0, 12'h7FF, 1'b0, 1'b1);  // failure, no measurement
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'h7FF, 1'b0, 1'b0);     // most positive sample
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'h800, 1'b0, 1'b0);     // most negative sample
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'h000, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_ENABLE, 1'b0, 12'h000, 1'b1, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1066, 1'b0, 1'b0);    // on each curve point
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1192, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1327, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1371, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1100, 1'b0, 1'b0);    // inside each segment
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1250, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1350, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1200, 1'b1, 1'b1);    // failed update
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1200, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_ENABLE, 1'b1, 12'hFFF, 1'b1, 1'b1);   // immediate, not a tick
    push_item(batlvl_pkg::MODE_DISABLE, 1'b0, 12'h000, 1'b0, 1'b0);  // unmatched disable
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1300, 1'b0, 1'b0);
    push_item(MODE_UNUSED, 1'b1, 12'hFFF, 1'b1, 1'b1);               // unused mode
    push_item(batlvl_pkg::MODE_DISABLE, 1'b0, 12'h000, 1'b1, 1'b1);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'd1300, 1'b0, 1'b0);
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'hFFF, 1'b0, 1'b0);     // truncation toward zero
    push_item(batlvl_pkg::MODE_TICK, 1'b1, 12'h001, 1'b0, 1'b0);
    s_tvalid <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin period_v = 16'd1; ref_v = 12'd4095; end
        1: begin period_v = 16'd0; ref_v = 12'd1; end         // countdown wraps
        2: begin period_v = 16'hFFFF; ref_v = 12'd3100; end
        3: begin
          period_v = 16'($urandom_range(2, 6));
          ref_v = 12'($urandom_range(1, 4095));
        end
        4: begin period_v = 16'($urandom_range(1, 12)); ref_v = 12'd3100; end
        default: begin
          period_v = 16'($urandom_range(2, 20));
          ref_v = 12'($urandom_range(2500, 4095));
        end
      endcase
      drain();
      write_reg(ADDR_PERIOD, {16'h0, period_v});
      write_reg(ADDR_REFERENCE, {20'h0, ref_v});
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_item(int'(ref_v));
      s_tvalid <= 1'b0;
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
src/batlvl_pkg.sv
src/battery_level_estimator_top.sv
tb/battery_level_checker.sv
tb/tb_battery_level_estimator_top.sv
